// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LSTW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lstw: assertion failed");

// Clocked assertion that also holds during reset.
`define LSTW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lstw: assertion failed");

`endif

// ----- rtl/core/lstw_pkg.sv -----
`default_nettype none

package lstw_pkg;

  localparam int unsigned TrigW     = 33;
  localparam int unsigned PhaseLat  = 3;
  localparam int unsigned XformLat  = 7;
  localparam logic signed [TrigW-1:0] CordicStart = 33'sd652032874;

  typedef enum logic [2:0] {
    CfgMaxRange = 3'd0,
    CfgMinRange = 3'd1,
    CfgTilt     = 3'd2,
    CfgOffX     = 3'd3,
    CfgOffY     = 3'd4,
    CfgOffZ     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]        range_mm;
    logic               ignore_flag;
    logic signed [15:0] beam_angle;
    logic signed [15:0] heading_taken;
    logic signed [23:0] robot_x_mm;
    logic signed [23:0] robot_y_mm;
  } in_item_t;

  typedef struct packed {
    logic signed [27:0] world_x;
    logic signed [27:0] world_y;
    logic signed [27:0] world_z;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        range_mm;
    logic signed [23:0] robot_x_mm;
    logic signed [23:0] robot_y_mm;
  } side_t;

  typedef struct packed {
    logic signed [15:0] offset_x_mm;
    logic signed [15:0] offset_y_mm;
    logic signed [15:0] offset_z_mm;
  } offs_t;

  typedef struct packed {
    logic                    neg;
    logic signed [TrigW-1:0] z;
  } phase_t;

  typedef struct packed {
    logic signed [TrigW-1:0] cos_v;
    logic signed [TrigW-1:0] sin_v;
  } trig_t;

  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lstw_phase.sv -----
`default_nettype none

module lstw_phase import lstw_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output phase_t             phase_o
);

  localparam int unsigned RecipShift = 38;
  localparam logic [26:0] RecipM   = 27'(((64'd1 << RecipShift) + 64'd2249) / 64'd2250);
  localparam logic [16:0] StepHi   = 17'd119304;
  localparam logic [10:0] StepLo   = 11'd1456;
  localparam logic [10:0] HalfDen  = 11'd1125;
  localparam logic signed [16:0] FullTurn = 17'sd36000;

  logic signed [16:0] a_s;
  logic [15:0]        a;
  logic [31:0]        hi_d, hi1_q, hi2_q;
  logic [25:0]        mm_d, mm_q;
  logic [14:0]        q_d, q_q;
  logic [31:0]        ph, ph_f;
  logic               neg_d;
  phase_t             phase_q;

  always_comb begin
    a_s  = {angle_i[15], angle_i};
    if (a_s < 0) begin
      a_s = a_s + FullTurn;
    end
    a    = a_s[15:0];
    hi_d = 32'({17'd0, a} * {16'd0, StepHi});
    mm_d = 26'({10'd0, a} * {15'd0, StepLo}) + {15'd0, HalfDen};
    q_d  = 15'(({27'd0, mm_q} * {26'd0, RecipM}) >> RecipShift);
  end

  always_comb begin
    ph    = hi2_q + {17'd0, q_q};
    ph_f  = ph;
    neg_d = 1'b0;
    if (ph[31:30] == 2'b01 || ph[31:30] == 2'b10) begin
      ph_f  = ph + 32'h8000_0000;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi1_q     <= hi_d;
      mm_q      <= mm_d;
      hi2_q     <= hi1_q;
      q_q       <= q_d;
      phase_q.z <= {ph_f[31], ph_f};
      phase_q.neg <= neg_d;
    end
  end

  assign phase_o = phase_q;

endmodule

`default_nettype wire

// ----- rtl/core/lstw_cordic.sv -----
`default_nettype none

module lstw_cordic import lstw_pkg::*; #(
  parameter int unsigned Stages = 16
) (
  input  logic   clk_i,
  input  logic   en_i,
  input  phase_t phase_i,
  output trig_t  trig_o
);

  logic signed [TrigW-1:0] x_q [Stages];
  logic signed [TrigW-1:0] y_q [Stages];
  logic signed [TrigW-1:0] z_q [Stages-1];
  logic                    neg_q [Stages];
  trig_t                   trig_q;

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic signed [TrigW-1:0] xi, yi, zi;
    logic                    ni;

    if (i == 0) begin : g_first
      assign xi = CordicStart;
      assign yi = '0;
      assign zi = phase_i.z;
      assign ni = phase_i.neg;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign ni = neg_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i] <= ni;
        if (!zi[TrigW-1]) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
        end else begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
        end
      end
    end

    if (i < Stages - 1) begin : g_angle
      logic signed [TrigW-1:0] at;

      assign at = $signed({1'b0, atan_turn(i)});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= zi[TrigW-1] ? zi + at : zi - at;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.cos_v <= neg_q[Stages-1] ? -x_q[Stages-1] : x_q[Stages-1];
      trig_q.sin_v <= neg_q[Stages-1] ? -y_q[Stages-1] : y_q[Stages-1];
    end
  end

  assign trig_o = trig_q;

endmodule

`default_nettype wire

// ----- rtl/core/lstw_xform.sv -----
`default_nettype none

module lstw_xform import lstw_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  side_t     side_i,
  input  offs_t     offs_i,
  input  trig_t     beam_i,
  input  trig_t     tilt_i,
  input  trig_t     head_i,
  output out_item_t item_o
);

  function automatic logic signed [27:0] sat28(input logic signed [31:0] v);
    logic signed [27:0] r;
    if (v > 32'sd134217727) begin
      r = 28'sh7FFFFFF;
    end else if (v < -32'sd134217728) begin
      r = 28'sh8000000;
    end else begin
      r = v[27:0];
    end
    return r;
  endfunction

  logic signed [49:0] pbx_q, pby_q;
  logic signed [31:0] rawx_q, rawy_q, rawy3_q;
  logic signed [64:0] ptx_q, ptz_q;
  logic signed [31:0] lx_q, ly_q, lz_q, lz5_q, lz6_q;
  logic signed [65:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [66:0] sx_q, sy_q;
  trig_t              tl1_q, tl2_q;
  trig_t              hd1_q, hd2_q, hd3_q, hd4_q;
  side_t              sd1_q, sd2_q, sd3_q, sd4_q, sd5_q, sd6_q;
  logic signed [31:0] wx, wy, wz;
  out_item_t          item_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pbx_q   <= $signed({1'b0, side_i.range_mm}) * beam_i.cos_v;
      pby_q   <= $signed({1'b0, side_i.range_mm}) * beam_i.sin_v;
      tl1_q   <= tilt_i;
      hd1_q   <= head_i;
      sd1_q   <= side_i;

      rawx_q  <= 32'((pbx_q + 50'sd131072) >>> 18);
      rawy_q  <= 32'((pby_q + 50'sd131072) >>> 18);
      tl2_q   <= tl1_q;
      hd2_q   <= hd1_q;
      sd2_q   <= sd1_q;

      ptx_q   <= rawx_q * tl2_q.cos_v;
      ptz_q   <= rawx_q * tl2_q.sin_v;
      rawy3_q <= rawy_q;
      hd3_q   <= hd2_q;
      sd3_q   <= sd2_q;

      lx_q    <= 32'((ptx_q + 65'sd536870912) >>> 30)
                 + 32'($signed({offs_i.offset_x_mm, 12'd0}));
      ly_q    <= rawy3_q + 32'($signed({offs_i.offset_y_mm, 12'd0}));
      lz_q    <= 32'((ptz_q + 65'sd536870912) >>> 30)
                 + 32'($signed({offs_i.offset_z_mm, 12'd0}));
      hd4_q   <= hd3_q;
      sd4_q   <= sd3_q;

      p1_q    <= lx_q * hd4_q.cos_v;
      p2_q    <= ly_q * hd4_q.sin_v;
      p3_q    <= lx_q * hd4_q.sin_v;
      p4_q    <= ly_q * hd4_q.cos_v;
      lz5_q   <= lz_q;
      sd5_q   <= sd4_q;

      sx_q    <= 67'(p1_q) - 67'(p2_q);
      sy_q    <= 67'(p3_q) + 67'(p4_q);
      lz6_q   <= lz5_q;
      sd6_q   <= sd5_q;

      item_q.world_x <= sat28(wx);
      item_q.world_y <= sat28(wy);
      item_q.world_z <= sat28(wz);
    end
  end

  always_comb begin
    wx = 32'((sx_q + 67'sd137438953472) >>> 38) + 32'($signed({sd6_q.robot_x_mm, 4'd0}));
    wy = 32'((sy_q + 67'sd137438953472) >>> 38) + 32'($signed({sd6_q.robot_y_mm, 4'd0}));
    wz = (lz6_q + 32'sd128) >>> 8;
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// ----- rtl/core/laser_scan_to_world_points.sv -----
// Laser scan to world points.
// Input channel: one range reading per item (in_valid_i, in_stall_o, in_item_i).
// Output channel: one world point per kept item (out_valid_o, out_stall_i,
// out_item_o), in 1/16 mm units, saturated to 28 bits signed.
// Flagged readings and readings outside the min/max range produce no item.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i; cfg_ready_o is
// always high. Write registers only while no item is in flight.
// Pipeline: an accepted item passes through the angle-to-phase conversion
// registers, the CORDIC stages and their output register, the multiply and
// add registers of the transform, and the final output register.
// Throughput: one item per cycle while in_stall_o is low, set by the fully pipelined datapath.
// When the receiver stalls, the output register holds its item and the
// pipeline keeps moving until its last stage holds an item; then in_stall_o
// rises and everything holds.
// Reset clears all valid bits and restores the configuration defaults.
`default_nettype none

module laser_scan_to_world_points import lstw_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned SideDepth  = PhaseLat + CORDIC_STAGES + 1;
  localparam int unsigned ValidDepth = SideDepth + XformLat;

  logic [15:0]        max_q, min_q;
  logic signed [14:0] tilt_q;
  offs_t              offs_q;
  logic               drop, en;
  logic               vld_q [ValidDepth];
  side_t              side_q [SideDepth];
  phase_t             ph_beam, ph_tilt, ph_head;
  trig_t              tr_beam, tr_tilt, tr_head;
  out_item_t          xf_item, out_item_q;
  logic               out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= 16'hFFFF;
      min_q  <= 16'h0000;
      tilt_q <= '0;
      offs_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgMaxRange: max_q <= cfg_data_i;
        CfgMinRange: min_q <= cfg_data_i;
        CfgTilt:     tilt_q <= cfg_data_i[14:0];
        CfgOffX:     offs_q.offset_x_mm <= cfg_data_i;
        CfgOffY:     offs_q.offset_y_mm <= cfg_data_i;
        CfgOffZ:     offs_q.offset_z_mm <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign drop = in_item_i.ignore_flag || (in_item_i.range_mm > max_q)
                || (in_item_i.range_mm < min_q);
  assign en = !(vld_q[ValidDepth-1] && out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ValidDepth; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i && !drop;
      for (int k = 1; k < ValidDepth; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].range_mm   <= in_item_i.range_mm;
      side_q[0].robot_x_mm <= in_item_i.robot_x_mm;
      side_q[0].robot_y_mm <= in_item_i.robot_y_mm;
      for (int k = 1; k < SideDepth; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  lstw_phase u_phase_beam (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_item_i.beam_angle),
    .phase_o (ph_beam)
  );

  lstw_phase u_phase_tilt (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i ({tilt_q[14], tilt_q}),
    .phase_o (ph_tilt)
  );

  lstw_phase u_phase_head (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_item_i.heading_taken),
    .phase_o (ph_head)
  );

  lstw_cordic #(.Stages(CORDIC_STAGES)) u_cordic_beam (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (ph_beam),
    .trig_o  (tr_beam)
  );

  lstw_cordic #(.Stages(CORDIC_STAGES)) u_cordic_tilt (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (ph_tilt),
    .trig_o  (tr_tilt)
  );

  lstw_cordic #(.Stages(CORDIC_STAGES)) u_cordic_head (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (ph_head),
    .trig_o  (tr_head)
  );

  lstw_xform u_xform (
    .clk_i  (clk_i),
    .en_i   (en),
    .side_i (side_q[SideDepth-1]),
    .offs_i (offs_q),
    .beam_i (tr_beam),
    .tilt_i (tr_tilt),
    .head_i (tr_head),
    .item_o (xf_item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= vld_q[ValidDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_item_q <= xf_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ----- rtl/core/lstw_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module lstw_checker import lstw_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o,
  input logic      cfg_ready_o
);

  `LSTW_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
  `LSTW_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i)
  `LSTW_ASSERT(a_stall_release, clk_i, rst_ni, !out_valid_o |-> !in_stall_o)
  `LSTW_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o)

endmodule

bind laser_scan_to_world_points lstw_checker u_lstw_checker (.*);

`default_nettype wire

// ----- sim/tb_laser_scan_to_world_points.sv -----
`default_nettype none

module tb_laser_scan_to_world_points;
  import lstw_pkg::*;

  localparam int unsigned Stages = 16;
  localparam int unsigned Latency = Stages + 11;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  laser_scan_to_world_points #(.CORDIC_STAGES(Stages)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0] max_range_q, min_range_q;
  logic signed [14:0] tilt_q;
  logic signed [15:0] off_x_q, off_y_q, off_z_q;

  out_item_t expected_points[$];
  int unsigned mismatches = 0;
  int unsigned points_seen = 0;
  int unsigned dropped = 0;
  int unsigned burst_left = 0;

  function automatic longint floor_sh(longint v, int unsigned sh);
    return v >>> sh;
  endfunction

  function automatic longint round_sh(longint v, int unsigned sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp28(longint v);
    if (v > 134217727) return 134217727;
    if (v < -134217728) return -134217728;
    return v;
  endfunction

  function automatic void sin_cos(input longint centideg, output longint c,
                                  output longint s);
    longint a, x, y, z, dx, dy;
    logic [63:0] ph;
    logic [31:0] p;
    logic flip;
    a = centideg % 36000;
    if (a < 0) a += 36000;
    ph = ((64'(a) << 32) + 64'd18000) / 64'd36000;
    p = ph[31:0];
    flip = 1'b0;
    if (p[31:30] == 2'd1 || p[31:30] == 2'd2) begin
      p = p + 32'h80000000;
      flip = 1'b1;
    end
    z = longint'($signed(p));
    x = 652032874;
    y = 0;
    for (int i = 0; i < Stages; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic bit project_point(in_item_t it, output out_item_t pt);
    longint cb, sb, ct, st, ch, sh, r, rawx, rawy, lx, ly, lz;
    if (it.ignore_flag || it.range_mm > max_range_q || it.range_mm < min_range_q)
      return 1'b0;
    r = longint'(it.range_mm);
    sin_cos(longint'(it.beam_angle), cb, sb);
    sin_cos(longint'(tilt_q), ct, st);
    sin_cos(longint'(it.heading_taken), ch, sh);
    rawx = round_sh(r * cb, 18);
    rawy = round_sh(r * sb, 18);
    lx = round_sh(rawx * ct, 30) + longint'(off_x_q) * 4096;
    ly = rawy + longint'(off_y_q) * 4096;
    lz = round_sh(rawx * st, 30) + longint'(off_z_q) * 4096;
    pt.world_x = 28'(clamp28(round_sh(lx * ch - ly * sh, 38) + longint'(it.robot_x_mm) * 16));
    pt.world_y = 28'(clamp28(round_sh(lx * sh + ly * ch, 38) + longint'(it.robot_y_mm) * 16));
    pt.world_z = 28'(clamp28(round_sh(lz, 8)));
    return 1'b1;
  endfunction

  task automatic send_reading(in_item_t it);
    out_item_t pt;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (project_point(it, pt)) expected_points = {expected_points, pt};
    else dropped++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgMaxRange: max_range_q = val;
      CfgMinRange: min_range_q = val;
      CfgTilt:     tilt_q = val[14:0];
      CfgOffX:     off_x_q = val;
      CfgOffY:     off_y_q = val;
      CfgOffZ:     off_z_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic set_mount(logic [15:0] mx, logic [15:0] mn, logic signed [14:0] tl,
                           logic [15:0] ox, logic [15:0] oy, logic [15:0] oz);
    drain();
    write_reg(CfgMaxRange, mx);
    write_reg(CfgMinRange, mn);
    write_reg(CfgTilt, 16'(tl));
    write_reg(CfgOffX, ox);
    write_reg(CfgOffY, oy);
    write_reg(CfgOffZ, oz);
  endtask

  function automatic in_item_t random_reading(bit wide_angles);
    in_item_t it;
    it.range_mm = $urandom_range(0, 3) == 0 ? 16'(65535 - $urandom_range(0, 3))
                                          : 16'($urandom());
    it.ignore_flag = ($urandom_range(0, 7) == 0);
    if (wide_angles) begin
      it.beam_angle = 16'($urandom());
      it.heading_taken = 16'($urandom());
    end else begin
      it.beam_angle = 16'($signed($urandom_range(0, 36000)) - 18000);
      it.heading_taken = 16'($signed($urandom_range(0, 36000)) - 18000);
    end
    it.robot_x_mm = 24'($urandom());
    it.robot_y_mm = 24'($urandom());
    return it;
  endfunction

  function automatic in_item_t reading(logic [15:0] r, logic ign, int beam, int head,
                                       int px, int py);
    in_item_t it;
    it.range_mm = r;
    it.ignore_flag = ign;
    it.beam_angle = 16'(beam);
    it.heading_taken = 16'(head);
    it.robot_x_mm = 24'(px);
    it.robot_y_mm = 24'(py);
    return it;
  endfunction

  task automatic test_defaults_extremes;
    send_reading(reading(0, 0, 0, 0, 0, 0));
    send_reading(reading(65535, 0, 18000, -18000, 8388607, -8388608));
    send_reading(reading(65535, 0, -18000, 18000, -8388608, 8388607));
    send_reading(reading(1000, 1, 4500, 0, 0, 0));
    send_reading(reading(1000, 0, 9000, 9000, 100, -100));
    send_reading(reading(1000, 0, -9000, -9000, 0, 0));
    send_reading(reading(65535, 0, 32767, -32768, 8388607, 8388607));
    send_reading(reading(65535, 0, -32768, 32767, -8388608, -8388608));
    send_reading(reading(30000, 0, 27000, -27000, 5, 5));
  endtask

  task automatic test_range_gate;
    set_mount(16'd5000, 16'd1000, 15'sd0, 16'd0, 16'd0, 16'd0);
    send_reading(reading(999, 0, 100, 0, 0, 0));
    send_reading(reading(1000, 0, 100, 0, 0, 0));
    send_reading(reading(5000, 0, 100, 0, 0, 0));
    send_reading(reading(5001, 0, 100, 0, 0, 0));
    set_mount(16'd100, 16'd200, 15'sd0, 16'd0, 16'd0, 16'd0);
    send_reading(reading(150, 0, 0, 0, 0, 0));
    drain();
    write_reg(cfg_idx_e'(3'd7), 16'hFFFF);
    send_reading(reading(150, 0, 0, 0, 0, 0));
  endtask

  task automatic test_mount_extremes;
    set_mount(16'hFFFF, 16'd0, 15'sd9000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_reading(reading(65535, 0, 0, 4500, 8388607, -8388608));
    send_reading(reading(65535, 0, 18000, -4500, -8388608, 8388607));
    set_mount(16'hFFFF, 16'd0, -15'sd9000, 16'h8000, 16'h7FFF, 16'h8000);
    send_reading(reading(65535, 0, 0, 13500, 8388607, 8388607));
    send_reading(reading(65535, 0, 9000, -13500, -8388608, -8388608));
  endtask

  task automatic test_random_stream(int unsigned n, bit wide_angles);
    for (int unsigned i = 0; i < n; i++) send_reading(random_reading(wide_angles));
  endtask

  task automatic test_random_mounts;
    for (int k = 0; k < 6; k++) begin
      set_mount(16'($urandom_range(20000, 65535)), 16'($urandom_range(0, 20000)),
                15'(int'($urandom_range(0, 18000)) - 9000), 16'($urandom()),
                16'($urandom()), 16'($urandom()));
      test_random_stream(200, k[0]);
    end
  endtask

  initial begin
    max_range_q = 16'hFFFF;
    min_range_q = '0;
    tilt_q = '0;
    off_x_q = '0;
    off_y_q = '0;
    off_z_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_extremes();
    test_range_gate();
    test_mount_extremes();
    set_mount(16'hFFFF, 16'd0, 15'sd0, 16'd0, 16'd0, 16'd0);
    test_random_stream(300, 1'b0);
    test_random_mounts();
    drain();
    $display("Checked %0d world points, %0d readings dropped by the range gate or flag.",
             points_seen, dropped);
    $display("Mount settings covered tilt and offset extremes and random values.");
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (($urandom_range(0, 255) & 8'hC0) == 0) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 4) == 0);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected world point %h", out_item_o);
      end else begin
        want = expected_points.pop_front();
        if (out_item_o.world_x !== want.world_x || out_item_o.world_y !== want.world_y ||
            out_item_o.world_z !== want.world_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     want.world_x, want.world_y, want.world_z,
                     out_item_o.world_x, out_item_o.world_y, out_item_o.world_z);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
